// File: hw/rtl/jvs_pkg.sv
// Package for the JSON value scanner: scan phases, transfer payload structs,
// character constants and default sizes. No dependencies.
package jvs_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int JVS_MAX_CAPACITY = 256;
    localparam int JVS_DEPTH_WIDTH  = 8;

    // Width of the fixed capacity field of an input transfer.
    localparam int JVS_LEN_W = 9;

    // Characters that steer the scan.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Operation codes taken at the start of a scan.
    localparam logic OP_READ = 1'b0;
    localparam logic OP_SKIP = 1'b1;

    // Scan phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WS   = 3'd1,
        PH_STR  = 3'd2,
        PH_ESC  = 3'd3,
        PH_BARE = 3'd4,
        PH_NEST = 3'd5,
        PH_NSTR = 3'd6,
        PH_NESC = 3'd7
    } jvs_phase_t;

    // Payload of one input transfer.
    typedef struct packed {
        logic [7:0]           data_byte;
        logic                 start_value;
        logic                 operation;
        logic [JVS_LEN_W-1:0] max_length;
    } jvs_item_t;

    // Payload of one result transfer.
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       value_done;
        logic       ending_consumed;
    } jvs_result_t;

    // Whitespace accepted between tokens.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // Characters that close a bare scalar.
    function automatic logic is_close(input logic [7:0] b);
        return (b == CH_COMMA) || (b == CH_RBRACE) || (b == CH_RBRACK);
    endfunction

endpackage

// File: hw/rtl/json_value_scanner_unit.sv
// JSON value scanner: the result of each input transfer is registered in the
// output register; throughput one byte per cycle while item_stall is low, set
// by the update of the phase register and counters on each transfer. A skid
// register behind the output register takes one more input transfer while a
// result is stalled, after which the input stalls until the output drains.
// Reset (rst_n low, asynchronous) returns the scan to idle with zero depth
// and count and a capacity of one; output and skid registers are emptied.
// Depends on jvs_pkg.
module json_value_scanner_unit #(
    parameter int MAX_CAPACITY = jvs_pkg::JVS_MAX_CAPACITY,
    parameter int DEPTH_WIDTH  = jvs_pkg::JVS_DEPTH_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  jvs_pkg::jvs_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output jvs_pkg::jvs_result_t result
);
    import jvs_pkg::*;

    localparam int CAP_W = $clog2(MAX_CAPACITY + 1);
    localparam int CMP_W = (CAP_W > JVS_LEN_W) ? CAP_W : JVS_LEN_W;
    localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};

    // Scan state.
    jvs_phase_t             phase_reg, phase_next;
    logic [DEPTH_WIDTH-1:0] depth_reg, depth_next;
    logic [CAP_W-1:0]       count_reg, count_next;
    logic                   mode_reg, mode_next;
    logic [CAP_W-1:0]       capacity_reg, capacity_next;
    logic                   brace_reg, brace_next;

    // Output and skid registers.
    logic        out_valid_reg;
    jvs_result_t out_reg;
    logic        skid_valid_reg;
    jvs_result_t skid_reg;

    // State as seen by the current byte, after a start has taken effect.
    jvs_phase_t             eff_phase;
    logic [DEPTH_WIDTH-1:0] eff_depth;
    logic [CAP_W-1:0]       eff_count;
    logic                   eff_skip;
    logic [CAP_W-1:0]       eff_capacity;
    logic                   eff_brace;
    logic [CMP_W-1:0]       len_ext;
    logic [CAP_W-1:0]       len_clamped;

    logic        can_store;
    logic [7:0]  esc_char;
    logic [7:0]  b;
    logic [7:0]  nest_open;
    logic [7:0]  nest_close;
    jvs_result_t res;

    logic in_fire;

    assign b          = item.data_byte;
    assign item_stall = skid_valid_reg;
    assign in_fire    = item_valid && !item_stall;

    // Capacity clamp and effective state after an optional start.
    always_comb
    begin
        len_ext = CMP_W'(item.max_length);
        if (len_ext > CMP_W'(MAX_CAPACITY))
        begin
            len_clamped = CAP_W'(MAX_CAPACITY);
        end
        else
        begin
            len_clamped = CAP_W'(len_ext);
        end

        if (item.start_value)
        begin
            eff_phase    = PH_WS;
            eff_depth    = '0;
            eff_count    = '0;
            eff_skip     = (item.operation == OP_SKIP);
            eff_capacity = len_clamped;
            eff_brace    = 1'b0;
        end
        else
        begin
            eff_phase    = phase_reg;
            eff_depth    = depth_reg;
            eff_count    = count_reg;
            eff_skip     = mode_reg;
            eff_capacity = capacity_reg;
            eff_brace    = brace_reg;
        end
    end

    // Room for one more byte ahead of the terminator.
    assign can_store  = ({1'b0, eff_count} + 1'b1) < {1'b0, eff_capacity};
    assign nest_open  = eff_brace ? CH_LBRACE : CH_LBRACK;
    assign nest_close = eff_brace ? CH_RBRACE : CH_RBRACK;

    // Escape translation.
    always_comb
    begin
        unique case (b)
            CH_LOW_N: esc_char = CH_LF;
            CH_LOW_R: esc_char = CH_CR;
            CH_LOW_T: esc_char = CH_TAB;
            default:  esc_char = b;
        endcase
    end

    // Result of the current byte.
    always_comb
    begin
        res = '0;
        unique case (eff_phase)
            PH_WS:
            begin
                if (!is_ws(b))
                begin
                    if (b == CH_NUL)
                    begin
                        res.value_done = 1'b1;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        res.value_done = 1'b0;
                    end
                    else if (eff_skip && (b == CH_LBRACE || b == CH_LBRACK))
                    begin
                        res.value_done = 1'b0;
                    end
                    else if (is_close(b))
                    begin
                        res.value_done = 1'b1;
                    end
                    else if (!eff_skip && can_store)
                    begin
                        res.char_valid = 1'b1;
                        res.char_out   = b;
                    end
                end
            end
            PH_STR:
            begin
                if (b == CH_NUL)
                begin
                    res.value_done = 1'b1;
                end
                else if (b == CH_QUOTE)
                begin
                    res.value_done      = 1'b1;
                    res.ending_consumed = 1'b1;
                end
                else if (b != CH_BSLASH && !eff_skip && can_store)
                begin
                    res.char_valid = 1'b1;
                    res.char_out   = b;
                end
            end
            PH_ESC:
            begin
                if (b == CH_NUL)
                begin
                    res.value_done = 1'b1;
                end
                else if (!eff_skip && can_store)
                begin
                    res.char_valid = 1'b1;
                    res.char_out   = esc_char;
                end
            end
            PH_BARE:
            begin
                if (b == CH_NUL || is_close(b) || (!eff_skip && is_ws(b)))
                begin
                    res.value_done = 1'b1;
                end
                else if (!eff_skip && can_store)
                begin
                    res.char_valid = 1'b1;
                    res.char_out   = b;
                end
            end
            PH_NEST:
            begin
                if (b == CH_NUL)
                begin
                    res.value_done = 1'b1;
                end
                else if (b != CH_QUOTE && b != nest_open && b == nest_close
                         && eff_depth <= DEPTH_WIDTH'(1))
                begin
                    res.value_done      = 1'b1;
                    res.ending_consumed = 1'b1;
                end
            end
            PH_NSTR, PH_NESC:
            begin
                res.value_done = (b == CH_NUL);
            end
            PH_IDLE:
            begin
                res = '0;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // Next scan state.
    always_comb
    begin
        phase_next    = eff_phase;
        depth_next    = eff_depth;
        count_next    = res.char_valid ? eff_count + 1'b1 : eff_count;
        mode_next     = eff_skip;
        capacity_next = eff_capacity;
        brace_next    = eff_brace;
        unique case (eff_phase)
            PH_WS:
            begin
                if (!is_ws(b))
                begin
                    if (b == CH_NUL)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        phase_next = PH_STR;
                    end
                    else if (eff_skip && (b == CH_LBRACE || b == CH_LBRACK))
                    begin
                        brace_next = (b == CH_LBRACE);
                        depth_next = DEPTH_WIDTH'(1);
                        phase_next = PH_NEST;
                    end
                    else if (is_close(b))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_BARE;
                    end
                end
            end
            PH_STR:
            begin
                if (b == CH_NUL || b == CH_QUOTE)
                begin
                    phase_next = PH_IDLE;
                end
                else if (b == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC:
            begin
                phase_next = (b == CH_NUL) ? PH_IDLE : PH_STR;
            end
            PH_BARE:
            begin
                if (res.value_done)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_NEST:
            begin
                if (b == CH_NUL)
                begin
                    phase_next = PH_IDLE;
                end
                else if (b == CH_QUOTE)
                begin
                    phase_next = PH_NSTR;
                end
                else if (b == nest_open)
                begin
                    if (eff_depth != DEPTH_MAX)
                    begin
                        depth_next = eff_depth + 1'b1;
                    end
                end
                else if (b == nest_close)
                begin
                    if (eff_depth != '0)
                    begin
                        depth_next = eff_depth - 1'b1;
                    end
                    if (eff_depth <= DEPTH_WIDTH'(1))
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_NSTR:
            begin
                if (b == CH_NUL)
                begin
                    phase_next = PH_IDLE;
                end
                else if (b == CH_QUOTE)
                begin
                    phase_next = PH_NEST;
                end
                else if (b == CH_BSLASH)
                begin
                    phase_next = PH_NESC;
                end
            end
            PH_NESC:
            begin
                phase_next = (b == CH_NUL) ? PH_IDLE : PH_NSTR;
            end
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Scan state registers, updated on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            depth_reg    <= '0;
            count_reg    <= '0;
            mode_reg     <= 1'b0;
            capacity_reg <= CAP_W'(1);
            brace_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            depth_reg    <= depth_next;
            count_reg    <= count_next;
            mode_reg     <= mode_next;
            capacity_reg <= capacity_next;
            brace_reg    <= brace_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload side of the output and skid registers.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= res;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // The skid register only fills behind a held output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register is empty");

    // The stored count never passes the latched capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= capacity_reg)
        else $error("stored count exceeds capacity");

    // A nested scan always has at least one open level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NEST || phase_reg == PH_NSTR || phase_reg == PH_NESC)
        |-> (depth_reg != '0))
        else $error("nested scan with zero depth");

    // A consumed ending byte is only reported with the end of the value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.ending_consumed) |-> result.value_done)
        else $error("ending consumed without value done");

endmodule
